// ===== rtl/core/upd_pkg.sv =====
// Shared types, constants and helpers of the URL percent decoder.
package upd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned NIB_W = 4;

	localparam logic [BYTE_W-1:0] PCT_CHAR = 8'h25;
	localparam logic [BYTE_W-1:0] CTRL_MAX = 8'd31;
	localparam logic [BYTE_W-1:0] DEL_CHAR = 8'd127;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_PCT  = 3'b010,
		PH_HIGH = 3'b100
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [NIB_W-1:0]  high_nibble;
		logic              error_seen;
	} dec_state_t;

	typedef struct packed {
		logic              has_result;
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              path_done;
		logic              path_status;
	} dec_result_t;

	localparam dec_state_t STATE_RESET = '{phase: PH_IDLE, high_nibble: '0, error_seen: 1'b0};

	// Bit 4 set marks a byte that is not a hex digit.
	function automatic logic [NIB_W:0] hex_value(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] diff;
		diff = '0;
		hex_value = {1'b1, {NIB_W{1'b0}}};
		case (c) inside
			[8'h30:8'h39]: begin
				diff = c - 8'h30;
				hex_value = {1'b0, diff[NIB_W-1:0]};
			end
			[8'h41:8'h46]: begin
				diff = c - 8'h37;
				hex_value = {1'b0, diff[NIB_W-1:0]};
			end
			[8'h61:8'h66]: begin
				diff = c - 8'h57;
				hex_value = {1'b0, diff[NIB_W-1:0]};
			end
			default: begin
				hex_value = {1'b1, {NIB_W{1'b0}}};
			end
		endcase
	endfunction

endpackage

// ===== rtl/core/upd_in_if.sv =====
// Raw path byte channel.
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

// ===== rtl/core/upd_out_if.sv =====
// Decoded byte and path status channel.
interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       path_done;
	logic       path_status;

	modport source (output valid, output out_byte, output byte_valid,
		output path_done, output path_status, input ready);
	modport sink (input valid, input out_byte, input byte_valid,
		input path_done, input path_status, output ready);
endinterface

// ===== rtl/core/upd_step.sv =====
// Per-byte decode step: next state and optional result for one raw byte.
module upd_step (
	input  upd_pkg::dec_state_t          st,
	input  logic [upd_pkg::BYTE_W-1:0]   in_byte,
	input  logic                         is_last,
	output upd_pkg::dec_state_t          st_nxt,
	output upd_pkg::dec_result_t         res
);
	import upd_pkg::*;

	logic [NIB_W:0]      digit;
	logic [BYTE_W-1:0]   esc_val;
	logic                emit;
	logic [BYTE_W-1:0]   emit_byte;
	dec_state_t          upd;

	assign digit   = hex_value(in_byte);
	assign esc_val = {st.high_nibble, digit[NIB_W-1:0]};

	always_comb begin
		upd       = st;
		emit      = 1'b0;
		emit_byte = '0;
		if (!st.error_seen) begin
			case (st.phase)
				PH_PCT: begin
					if (digit[NIB_W] || is_last) begin
						upd.error_seen = 1'b1;
					end else begin
						upd.high_nibble = digit[NIB_W-1:0];
						upd.phase       = PH_HIGH;
					end
				end
				PH_HIGH: begin
					upd.phase = PH_IDLE;
					if (digit[NIB_W] || esc_val <= CTRL_MAX || esc_val > DEL_CHAR) begin
						upd.error_seen = 1'b1;
					end else begin
						emit      = 1'b1;
						emit_byte = esc_val;
					end
				end
				default: begin
					upd.phase = PH_IDLE;
					if (in_byte == PCT_CHAR) begin
						if (is_last) begin
							upd.error_seen = 1'b1;
						end else begin
							upd.phase = PH_PCT;
						end
					end else if (in_byte <= CTRL_MAX || in_byte == DEL_CHAR) begin
						upd.error_seen = 1'b1;
					end else begin
						emit      = 1'b1;
						emit_byte = in_byte;
					end
				end
			endcase
		end
	end

	assign st_nxt          = is_last ? STATE_RESET : upd;
	assign res.has_result  = emit || is_last;
	assign res.out_byte    = emit_byte;
	assign res.byte_valid  = emit;
	assign res.path_done   = is_last;
	assign res.path_status = is_last && upd.error_seen;

endmodule

// ===== rtl/core/url_percent_decoder_core.sv =====
// URL percent decoder: one raw path byte in, zero or one decoded byte or status out.
// Takes one byte per clock and sustains that rate as long as the result side keeps up;
// each accepted byte passes the input register and then the result register before its result
// is presented. The % and first digit of a %XX escape and bytes after a rejection give no
// result unless they carry is_last, which always gives one result with path_done and the
// path status.
// raw.ready depends combinationally on decoded.ready while the result register is full.
module url_percent_decoder_core (
	input  logic           clk,
	input  logic           arst_n,
	upd_in_if.sink         raw,
	upd_out_if.source      decoded
);
	import upd_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   raw_byte_s1;
	logic                raw_last_s1;
	dec_state_t          state_q;
	dec_state_t          state_nxt;
	dec_result_t         step_res;
	logic                res_valid_s2;
	dec_result_t         res_s2;
	logic                out_free;
	logic                s1_take;

	upd_step u_step (
		.st      (state_q),
		.in_byte (raw_byte_s1),
		.is_last (raw_last_s1),
		.st_nxt  (state_nxt),
		.res     (step_res)
	);

	assign out_free  = !res_valid_s2 || decoded.ready;
	assign s1_take   = valid_s1 && (!step_res.has_result || out_free);
	assign raw.ready = !valid_s1 || s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			raw_byte_s1 <= raw.in_byte;
			raw_last_s1 <= raw.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (s1_take) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= s1_take && step_res.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_take && step_res.has_result) begin
			res_s2 <= step_res;
		end
	end

	assign decoded.valid       = res_valid_s2;
	assign decoded.out_byte    = res_s2.out_byte;
	assign decoded.byte_valid  = res_s2.byte_valid;
	assign decoded.path_done   = res_s2.path_done;
	assign decoded.path_status = res_s2.path_status;

`ifndef SYNTHESIS
	a_status_only_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.path_status |-> res_s2.path_done && !res_s2.byte_valid)
		else $error("path_status without path_done or with a byte");

	a_byte_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && !res_s2.byte_valid |-> res_s2.out_byte == '0)
		else $error("out_byte nonzero without byte_valid");

	a_state_cleared_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_take && raw_last_s1 |=> state_q == STATE_RESET)
		else $error("state not cleared after last byte");

	a_no_bytes_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		s1_take && state_q.error_seen |-> !step_res.byte_valid)
		else $error("byte emitted after rejection");
`endif

endmodule
